### rtl/jsli_pkg.sv
// jsli_pkg: shared types, widths and constants of the joint soft-limit integrator
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package jsli_pkg;

   localparam int NumAxes   = 4;
   localparam int NumLimits = 8;
   localparam int NumStages = 7;

   localparam int AngW      = 24;
   localparam int SpdW      = 21;
   localparam int MsW       = 16;
   localparam int LimW      = 19;
   localparam int AlarmW    = 10;
   localparam int CsrAddrW  = 4;
   localparam int LimIdxW   = 3;

   // delta datapath widths
   localparam int MagW      = SpdW;
   localparam int DparW     = SpdW + 1;
   localparam int QW        = 7;
   localparam int RemW      = 10;
   localparam int RW        = MsW + 2;
   localparam int PaW       = 30;
   localparam int PbW       = 27;
   localparam int QaW       = 20;
   localparam int DmagW     = 27;
   localparam int SumW      = 29;
   localparam int ParW      = 26;

   // divide by 1000
   localparam int            Div          = 1000;
   localparam int            DivW         = 10;
   localparam logic [DivW-1:0] DivK       = 10'd1000;
   localparam int            MsRecipW     = 11;
   localparam logic [MsRecipW-1:0] MsRecip = 11'd1049;
   localparam int            MsRecipShift = 20;
   localparam int            PaRecipW     = 23;
   localparam logic [PaRecipW-1:0] PaRecip = 23'd4294967;
   localparam int            PaRecipShift = 32;

   localparam int AngMax    = 8388607;
   localparam int AngMin    = -8388608;
   localparam int ParOffset = 90 * 1024;
   localparam int ParLow    = 20 * 1024;
   localparam int ParHigh   = 145 * 1024;

   localparam int AlarmParLow  = 8;
   localparam int AlarmParHigh = 9;

   typedef logic signed [AngW-1:0]  angle_type;
   typedef logic signed [SpdW-1:0]  speed_type;
   typedef logic signed [LimW-1:0]  limit_type;
   typedef logic        [MsW-1:0]   ms_type;
   typedef logic        [AlarmW-1:0] alarm_type;

   typedef enum logic [CsrAddrW-1:0] {
      REG_AXIS1_NEG = 4'd0,
      REG_AXIS1_POS = 4'd1,
      REG_AXIS2_NEG = 4'd2,
      REG_AXIS2_POS = 4'd3,
      REG_AXIS3_NEG = 4'd4,
      REG_AXIS3_POS = 4'd5,
      REG_AXIS4_NEG = 4'd6,
      REG_AXIS4_POS = 4'd7
   } reg_idx_type;

   localparam limit_type LimReset [NumLimits] = '{
      -19'sd138342, 19'sd138342, -19'sd8294, 19'sd82022,
      -19'sd6963, 19'sd87142, -19'sd148582, 19'sd148582
   };

   // speed direction flags carried along the delta pipeline
   typedef struct packed {
      logic               mode;
      logic [NumAxes-1:0] neg;
      logic [NumAxes-1:0] pos;
      logic               par_neg;
      logic               par_pos;
   } dir_type;

   typedef struct packed {
      dir_type                         dir;
      logic [NumAxes-1:0][DmagW-1:0]   dmag;
   } dlt_type;

endpackage

`default_nettype wire

### rtl/jsli_if.sv
// jsli_if: request, response and register-write channel interfaces
// depends on jsli_pkg
`timescale 1ns / 1ps
`default_nettype none

interface jsli_req_if import jsli_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      mode;
   speed_type axis1_speed;
   speed_type axis2_speed;
   speed_type axis3_speed;
   speed_type axis4_speed;
   ms_type    elapsed_ms;

   modport source (output valid, mode, axis1_speed, axis2_speed, axis3_speed, axis4_speed,
                   elapsed_ms, input ready);
   modport sink (input valid, mode, axis1_speed, axis2_speed, axis3_speed, axis4_speed,
                 elapsed_ms, output ready);
endinterface

interface jsli_rsp_if import jsli_pkg::*; ();
   logic      valid;
   logic      ready;
   angle_type angle1;
   angle_type angle2;
   angle_type angle3;
   angle_type angle4;
   alarm_type alarm_bits;
   logic      motion_blocked;
   logic      single_velocity_clear;

   modport source (output valid, angle1, angle2, angle3, angle4, alarm_bits, motion_blocked,
                   single_velocity_clear, input ready);
   modport sink (input valid, angle1, angle2, angle3, angle4, alarm_bits, motion_blocked,
                 single_velocity_clear, output ready);
endinterface

interface jsli_csr_if import jsli_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CsrAddrW-1:0] addr;
   limit_type           wdata;

   modport source (output valid, addr, wdata, input ready);
   modport sink (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

### rtl/jsli_delta.sv
// jsli_delta: seven-stage pipeline turning speed and elapsed ms into |speed*ms/1000|
// plus direction flags; depends on jsli_pkg and jsli_if
`timescale 1ns / 1ps
`default_nettype none

module jsli_delta import jsli_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   jsli_req_if.sink req_chan,
   input  logic    take,
   output logic    dlt_valid,
   output dlt_type dlt
);

   logic [NumStages-1:0] v_ff, v_in, en;

   logic                          s1_mode_ff;
   speed_type [NumAxes-1:0]       s1_spd_ff;
   ms_type                        s1_ms_ff;

   dir_type                       s2_dir_in, s2_dir_ff;
   logic [NumAxes-1:0][MagW-1:0]  s2_mag_in, s2_mag_ff;
   logic [QW-1:0]                 s2_qe_in, s2_qe_ff;
   ms_type                        s2_ms_ff;
   logic [MsW+MsRecipW-1:0]       qe_prod;
   logic signed [DparW-1:0]       dpar;

   logic [NumAxes-1:0][MagW-1:0]  s3_mag_ff;
   dir_type                       s3_dir_ff;
   logic [QW-1:0]                 s3_q_in, s3_q_ff;
   logic [RemW-1:0]               s3_r_in, s3_r_ff;
   logic [QW+DivW-1:0]            qk;
   logic signed [RW-1:0]          r_e, r_fix;

   dir_type                       s4_dir_ff;
   logic [NumAxes-1:0][PaW-1:0]   s4_pa_in, s4_pa_ff;
   logic [NumAxes-1:0][PbW-1:0]   s4_pb_in, s4_pb_ff;
   logic [MagW+RemW-1:0]          pa_full [NumAxes];
   logic [MagW+QW-1:0]            pb_full [NumAxes];

   dir_type                       s5_dir_ff;
   logic [NumAxes-1:0][PaW-1:0]   s5_pa_ff;
   logic [NumAxes-1:0][PbW-1:0]   s5_pb_ff;
   logic [NumAxes-1:0][QaW-1:0]   s5_qae_in, s5_qae_ff;
   logic [PaW+PaRecipW-1:0]       pr [NumAxes];

   dir_type                       s6_dir_ff;
   logic [NumAxes-1:0][PbW-1:0]   s6_pb_ff;
   logic [NumAxes-1:0][QaW-1:0]   s6_qa_in, s6_qa_ff;
   logic [QaW+DivW-1:0]           qk2 [NumAxes];
   logic [PaW-1:0]                rem [NumAxes];

   dir_type                       s7_dir_ff;
   logic [NumAxes-1:0][DmagW-1:0] s7_dmag_in, s7_dmag_ff;

   // stage flow control, a stage loads when empty or when it drains
   always_comb begin
      en[NumStages-1] = !v_ff[NumStages-1] || take;
      for (int i = NumStages - 2; i >= 0; i--) begin
         en[i] = !v_ff[i] || en[i+1];
      end
      v_in[0] = en[0] ? req_chan.valid : v_ff[0];
      for (int i = 1; i < NumStages; i++) begin
         v_in[i] = en[i] ? v_ff[i-1] : v_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_chan.ready = en[0];

   // input register
   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_mode_ff   <= req_chan.mode;
         s1_spd_ff[0] <= req_chan.axis1_speed;
         s1_spd_ff[1] <= req_chan.axis2_speed;
         s1_spd_ff[2] <= req_chan.axis3_speed;
         s1_spd_ff[3] <= req_chan.axis4_speed;
         s1_ms_ff     <= req_chan.elapsed_ms;
      end
   end

   // magnitudes, signs, coarse ms/1000
   always_comb begin
      qe_prod  = s1_ms_ff * MsRecip;
      s2_qe_in = qe_prod[MsRecipShift +: QW];
      dpar     = DparW'(s1_spd_ff[1]) - DparW'(s1_spd_ff[2]);
      s2_dir_in.mode    = s1_mode_ff;
      s2_dir_in.par_neg = dpar[DparW-1];
      s2_dir_in.par_pos = !dpar[DparW-1] && (dpar != '0);
      for (int k = 0; k < NumAxes; k++) begin
         s2_dir_in.neg[k] = s1_spd_ff[k][SpdW-1];
         s2_dir_in.pos[k] = !s1_spd_ff[k][SpdW-1] && (s1_spd_ff[k] != '0);
         s2_mag_in[k]     = s1_spd_ff[k][SpdW-1] ? MagW'(-s1_spd_ff[k]) : MagW'(s1_spd_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_dir_ff <= s2_dir_in;
         s2_mag_ff <= s2_mag_in;
         s2_qe_ff  <= s2_qe_in;
         s2_ms_ff  <= s1_ms_ff;
      end
   end

   // ms = 1000*q + r, estimate is exact or one too high
   always_comb begin
      qk    = s2_qe_ff * DivK;
      r_e   = $signed({2'b00, s2_ms_ff}) - $signed({1'b0, qk});
      r_fix = r_e + RW'(Div);
      if (r_e[RW-1]) begin
         s3_q_in = s2_qe_ff - QW'(1);
         s3_r_in = r_fix[RemW-1:0];
      end else begin
         s3_q_in = s2_qe_ff;
         s3_r_in = r_e[RemW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_dir_ff <= s2_dir_ff;
         s3_mag_ff <= s2_mag_ff;
         s3_q_ff   <= s3_q_in;
         s3_r_ff   <= s3_r_in;
      end
   end

   // |v|*r and |v|*q
   always_comb begin
      for (int k = 0; k < NumAxes; k++) begin
         pa_full[k]  = s3_mag_ff[k] * s3_r_ff;
         pb_full[k]  = s3_mag_ff[k] * s3_q_ff;
         s4_pa_in[k] = pa_full[k][PaW-1:0];
         s4_pb_in[k] = pb_full[k][PbW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s4_dir_ff <= s3_dir_ff;
         s4_pa_ff  <= s4_pa_in;
         s4_pb_ff  <= s4_pb_in;
      end
   end

   // reciprocal estimate of |v|*r/1000, exact or one low
   always_comb begin
      for (int k = 0; k < NumAxes; k++) begin
         pr[k]        = s4_pa_ff[k] * PaRecip;
         s5_qae_in[k] = pr[k][PaRecipShift +: QaW];
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s5_dir_ff <= s4_dir_ff;
         s5_pa_ff  <= s4_pa_ff;
         s5_pb_ff  <= s4_pb_ff;
         s5_qae_ff <= s5_qae_in;
      end
   end

   // remainder correction
   always_comb begin
      for (int k = 0; k < NumAxes; k++) begin
         qk2[k]      = s5_qae_ff[k] * DivK;
         rem[k]      = s5_pa_ff[k] - PaW'(qk2[k]);
         s6_qa_in[k] = s5_qae_ff[k] + QaW'(rem[k] >= PaW'(Div));
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s6_dir_ff <= s5_dir_ff;
         s6_pb_ff  <= s5_pb_ff;
         s6_qa_ff  <= s6_qa_in;
      end
   end

   always_comb begin
      for (int k = 0; k < NumAxes; k++) begin
         s7_dmag_in[k] = DmagW'(s6_pb_ff[k]) + DmagW'(s6_qa_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s7_dir_ff  <= s6_dir_ff;
         s7_dmag_ff <= s7_dmag_in;
      end
   end

   assign dlt_valid = v_ff[NumStages-1];
   assign dlt.dir   = s7_dir_ff;
   assign dlt.dmag  = s7_dmag_ff;

endmodule

`default_nettype wire

### rtl/joint_soft_limit_integrator_core.sv
// joint_soft_limit_integrator_core: angle state, soft-limit checks and response register
// depends on jsli_pkg, jsli_if and jsli_delta
// a request word passes the delta stages and the angle update into the response register
// throughput: one word per cycle unless the response side stalls; the delta pipeline
// drains into the angle update, which reads and writes angle registers in the same cycle
// reset: synchronous; angles and alarm latch go to zero, limits to their defaults,
// pipeline empties; no clearing pass, requests are taken in the first cycle after reset
`timescale 1ns / 1ps
`default_nettype none

module joint_soft_limit_integrator_core import jsli_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   jsli_req_if.sink   req_chan,
   jsli_rsp_if.source rsp_chan,
   jsli_csr_if.sink   csr_chan
);

   limit_type               lim_ff [NumLimits];
   logic                    csr_hit;

   angle_type [NumAxes-1:0] ang_ff, ang_in, ang_step_c;
   alarm_type               alarm_ff, alarm_in, alarm_c;
   logic [NumAxes-1:0]      push_c;
   logic                    blocked_c;
   logic signed [ParW-1:0]  par_c;
   logic signed [SumW-1:0]  dext [NumAxes];
   logic signed [SumW-1:0]  sum_c [NumAxes];
   angle_type [NumAxes-1:0] sat_c;

   logic                    dlt_valid;
   dlt_type                 dlt;
   logic                    take, load;

   logic                    out_v_ff, out_v_in;
   angle_type [NumAxes-1:0] out_ang_ff, out_ang_in;
   alarm_type               out_alarm_ff, out_alarm_in;
   logic                    out_blk_ff, out_blk_in;
   logic                    out_clr_ff, out_clr_in;

   jsli_delta u_delta (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .take      (take),
      .dlt_valid (dlt_valid),
      .dlt       (dlt)
   );

   // limit registers
   assign csr_chan.ready = 1'b1;

   always_comb begin
      unique case (csr_chan.addr) inside
         REG_AXIS1_NEG, REG_AXIS1_POS, REG_AXIS2_NEG, REG_AXIS2_POS,
         REG_AXIS3_NEG, REG_AXIS3_POS, REG_AXIS4_NEG, REG_AXIS4_POS: csr_hit = 1'b1;
         default: csr_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff <= LimReset;
      end else if (csr_chan.valid && csr_hit) begin
         lim_ff[csr_chan.addr[LimIdxW-1:0]] <= csr_chan.wdata;
      end
   end

   assign take = !out_v_ff || rsp_chan.ready;
   assign load = take && dlt_valid;

   // checks on the angles before this word's motion
   always_comb begin
      alarm_c = '0;
      for (int k = 0; k < NumAxes; k++) begin
         alarm_c[2*k]   = ang_ff[k] < AngW'(lim_ff[2*k]);
         alarm_c[2*k+1] = ang_ff[k] > AngW'(lim_ff[2*k+1]);
         push_c[k] = (alarm_c[2*k] && dlt.dir.neg[k]) || (alarm_c[2*k+1] && dlt.dir.pos[k]);
      end
      par_c = ParW'(ParOffset) + ParW'(ang_ff[1]) - ParW'(ang_ff[2]);
      alarm_c[AlarmParLow]  = par_c < ParW'(ParLow);
      alarm_c[AlarmParHigh] = par_c > ParW'(ParHigh);
      blocked_c = !dlt.dir.mode && ((|push_c) ||
                  (alarm_c[AlarmParLow] && dlt.dir.par_neg) ||
                  (alarm_c[AlarmParHigh] && dlt.dir.par_pos));
   end

   // integrate and saturate
   always_comb begin
      for (int k = 0; k < NumAxes; k++) begin
         dext[k]  = $signed({2'b00, dlt.dmag[k]});
         sum_c[k] = SumW'(ang_ff[k]) + (dlt.dir.neg[k] ? -dext[k] : dext[k]);
         if (sum_c[k] > SumW'(AngMax)) begin
            sat_c[k] = AngW'(AngMax);
         end else if (sum_c[k] < SumW'(AngMin)) begin
            sat_c[k] = AngW'(AngMin);
         end else begin
            sat_c[k] = sum_c[k][AngW-1:0];
         end
         ang_step_c[k] = blocked_c ? ang_ff[k] : sat_c[k];
      end
   end

   always_comb begin
      ang_in       = load ? ang_step_c : ang_ff;
      alarm_in     = (load && !dlt.dir.mode) ? alarm_c : alarm_ff;
      out_v_in     = take ? dlt_valid : out_v_ff;
      out_ang_in   = load ? ang_step_c : out_ang_ff;
      out_alarm_in = load ? (dlt.dir.mode ? alarm_ff : alarm_c) : out_alarm_ff;
      out_blk_in   = load ? blocked_c : out_blk_ff;
      out_clr_in   = load ? (!dlt.dir.mode && (alarm_c != '0)) : out_clr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_ff   <= '0;
         alarm_ff <= '0;
         out_v_ff <= 1'b0;
      end else begin
         ang_ff   <= ang_in;
         alarm_ff <= alarm_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ang_ff   <= out_ang_in;
      out_alarm_ff <= out_alarm_in;
      out_blk_ff   <= out_blk_in;
      out_clr_ff   <= out_clr_in;
   end

   assign rsp_chan.valid                 = out_v_ff;
   assign rsp_chan.angle1                = out_ang_ff[0];
   assign rsp_chan.angle2                = out_ang_ff[1];
   assign rsp_chan.angle3                = out_ang_ff[2];
   assign rsp_chan.angle4                = out_ang_ff[3];
   assign rsp_chan.alarm_bits            = out_alarm_ff;
   assign rsp_chan.motion_blocked        = out_blk_ff;
   assign rsp_chan.single_velocity_clear = out_clr_ff;

   // a blocked word always carries an alarm
   a_blk_needs_alarm: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.motion_blocked) |-> rsp_chan.single_velocity_clear)
      else $error("blocked response without velocity clear");

   a_blk_holds_angles: assert property (@(posedge clock) disable iff (reset)
      (load && blocked_c) |=> (ang_ff == $past(ang_ff)))
      else $error("angles moved on a blocked word");

   a_home_holds_alarm: assert property (@(posedge clock) disable iff (reset)
      (load && dlt.dir.mode) |=> (alarm_ff == $past(alarm_ff)))
      else $error("alarm latch changed during homing");

   a_rsp_tracks_state: assert property (@(posedge clock) disable iff (reset)
      load |=> (rsp_chan.angle1 == ang_ff[0] && rsp_chan.angle4 == ang_ff[3]))
      else $error("response angles differ from angle state");

endmodule

`default_nettype wire

### dv/joint_soft_limit_integrator_core_test.sv
// joint_soft_limit_integrator_core_test: self-checking bench for the joint soft-limit integrator,
// directed limit, homing, overflow and truncation ticks, then random motion under idling
// depends on jsli_pkg, jsli_if and joint_soft_limit_integrator_core
`timescale 1ns / 1ps

module joint_soft_limit_integrator_core_test;
   import jsli_pkg::*;

   localparam logic ModeNormal = 1'b0;
   localparam logic ModeHoming = 1'b1;
   localparam int   LimSpan    = 184320;
   localparam int   LimFloor   = -(2 ** (LimW - 1));
   localparam int   LimCeil    = 2 ** (LimW - 1) - 1;
   localparam int   SpdTop     = 2 ** (SpdW - 1) - 1;
   localparam int   FarAngle   = 250000;
   localparam int   MaxShown   = 10;

   typedef enum int {LIM_DEFAULT, LIM_ORDERED, LIM_EXTREME, LIM_ANY} lim_style_type;

   typedef logic [NumLimits-1:0][LimW-1:0] limit_set_type;

   typedef struct packed {
      logic                          mode;
      logic [NumAxes-1:0][SpdW-1:0]  speed;
      logic [MsW-1:0]                ms;
   } tick_word_type;

   typedef struct packed {
      logic [NumAxes-1:0][AngW-1:0]  angle;
      alarm_type                     alarms;
      logic                          blocked;
      logic                          vel_clear;
   } pose_word_type;

   logic clock;
   logic reset;

   jsli_req_if req_if ();
   jsli_rsp_if rsp_if ();
   jsli_csr_if csr_if ();

   joint_soft_limit_integrator_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // predicted block state
   limit_type     lim_regs [NumLimits];
   angle_type     joint_pos [NumAxes];
   alarm_type     alarm_hold;
   pose_word_type expected_poses [$];

   int src_idle_pct;
   int snk_idle_pct;
   int ticks_sent;
   int homing_sent;
   int poses_checked;
   int blocked_seen;
   int alarm_seen;
   int limit_sets;
   int mismatch_count;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic pose_word_type integrate_tick(input tick_word_type t);
      pose_word_type p;
      longint        spd [NumAxes];
      longint        par;
      longint        dpar;
      longint        nxt;
      alarm_type     al;
      logic          stop;
      int            k;
      al = '0;
      stop = 1'b0;
      for (k = 0; k < NumAxes; k++) spd[k] = longint'(speed_type'(t.speed[k]));
      if (t.mode == ModeNormal) begin
         // checks use the angles from before this tick
         par = ParOffset + longint'(joint_pos[1]) - longint'(joint_pos[2]);
         dpar = spd[1] - spd[2];
         for (k = 0; k < NumAxes; k++) begin
            if (joint_pos[k] < lim_regs[2*k]) begin
               al[2*k] = 1'b1;
               if (spd[k] < 0) stop = 1'b1;
            end
            if (joint_pos[k] > lim_regs[2*k+1]) begin
               al[2*k+1] = 1'b1;
               if (spd[k] > 0) stop = 1'b1;
            end
         end
         if (par < ParLow) begin
            al[AlarmParLow] = 1'b1;
            if (dpar < 0) stop = 1'b1;
         end
         if (par > ParHigh) begin
            al[AlarmParHigh] = 1'b1;
            if (dpar > 0) stop = 1'b1;
         end
         alarm_hold = al;
      end
      if (!stop) begin
         for (k = 0; k < NumAxes; k++) begin
            nxt = longint'(joint_pos[k]) + spd[k] * longint'(t.ms) / Div;
            if (nxt > AngMax) nxt = AngMax;
            if (nxt < AngMin) nxt = AngMin;
            joint_pos[k] = AngW'(nxt);
         end
      end
      for (k = 0; k < NumAxes; k++) p.angle[k] = joint_pos[k];
      p.alarms = alarm_hold;
      p.blocked = stop;
      p.vel_clear = (al != '0);
      return p;
   endfunction

   function automatic tick_word_type make_tick(input logic m, input int s1, input int s2,
                                               input int s3, input int s4, input int ms);
      tick_word_type t;
      t.mode = m;
      t.speed[0] = SpdW'(s1);
      t.speed[1] = SpdW'(s2);
      t.speed[2] = SpdW'(s3);
      t.speed[3] = SpdW'(s4);
      t.ms = MsW'(ms);
      return t;
   endfunction

   function automatic limit_set_type pick_limits(input lim_style_type style);
      limit_set_type s;
      int            lo;
      int            hi;
      int            tmp;
      int            i;
      for (i = 0; i < NumLimits; i++) s[i] = LimReset[i];
      case (style)
         LIM_ORDERED: begin
            for (i = 0; i < NumAxes; i++) begin
               lo = int'($urandom_range(2 * LimSpan)) - LimSpan;
               hi = int'($urandom_range(2 * LimSpan)) - LimSpan;
               if (lo > hi) begin
                  tmp = lo;
                  lo = hi;
                  hi = tmp;
               end
               s[2*i] = LimW'(lo);
               s[2*i+1] = LimW'(hi);
            end
         end
         LIM_EXTREME: begin
            for (i = 0; i < NumLimits; i++) begin
               case ($urandom_range(3))
                  0: s[i] = LimW'(LimFloor);
                  1: s[i] = LimW'(LimCeil);
                  2: s[i] = LimW'(-LimSpan);
                  default: s[i] = LimW'(LimSpan);
               endcase
            end
         end
         LIM_ANY: begin
            for (i = 0; i < NumLimits; i++) s[i] = LimW'($urandom());
         end
         default: ;
      endcase
      return s;
   endfunction

   task automatic send_tick(input tick_word_type t);
      while ($urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.mode <= t.mode;
      req_if.axis1_speed <= t.speed[0];
      req_if.axis2_speed <= t.speed[1];
      req_if.axis3_speed <= t.speed[2];
      req_if.axis4_speed <= t.speed[3];
      req_if.elapsed_ms <= t.ms;
      do @(posedge clock); while (!req_if.ready);
      expected_poses.push_back(integrate_tick(t));
      ticks_sent++;
      if (t.mode == ModeHoming) homing_sent++;
   endtask

   // drive the joints to given angles with one homing word, exact when each difference fits a speed
   task automatic place_joints(input int t1, input int t2, input int t3, input int t4);
      longint        diff [NumAxes];
      int            tgt [NumAxes];
      int            ms;
      int            k;
      tick_word_type t;
      tgt[0] = t1;
      tgt[1] = t2;
      tgt[2] = t3;
      tgt[3] = t4;
      ms = 1000;
      for (k = 0; k < NumAxes; k++) begin
         diff[k] = longint'(tgt[k]) - longint'(joint_pos[k]);
         if (diff[k] > SpdTop || diff[k] < -SpdTop) ms = 10000;
      end
      t.mode = ModeHoming;
      t.ms = MsW'(ms);
      for (k = 0; k < NumAxes; k++) t.speed[k] = SpdW'(diff[k] * Div / ms);
      send_tick(t);
   endtask

   task automatic wait_for_poses();
      req_if.valid <= 1'b0;
      while (expected_poses.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrAddrW-1:0] addr, input limit_type data);
      csr_if.valid <= 1'b1;
      csr_if.addr <= addr;
      csr_if.wdata <= data;
      do @(posedge clock); while (!csr_if.ready);
      if (addr < NumLimits) lim_regs[addr[LimIdxW-1:0]] = data;
   endtask

   task automatic program_limits(input limit_set_type s);
      int i;
      wait_for_poses();
      // an index past the last limit must be ignored
      write_reg(CsrAddrW'(NumLimits + $urandom_range(2 ** CsrAddrW - NumLimits - 1)),
                LimW'($urandom()));
      for (i = 0; i < NumLimits; i++) write_reg(reg_idx_type'(i), s[i]);
      csr_if.valid <= 1'b0;
      limit_sets++;
   endtask

   task automatic test_reset_defaults();
      send_tick(make_tick(ModeNormal, 0, 0, 0, 0, 0));
      send_tick(make_tick(ModeNormal, 1024000, -1024000, 3000, -3000, 50));
   endtask

   task automatic test_overflow_and_homing();
      send_tick(make_tick(ModeHoming, SpdTop, -SpdTop - 1, 1024000, -1024000, 65535));
      // zero speed with every axis past a limit raises alarms but does not block
      send_tick(make_tick(ModeNormal, 0, 0, 0, 0, 65535));
      send_tick(make_tick(ModeHoming, -1, 1, 0, 0, 65535));
      send_tick(make_tick(ModeNormal, 1, 0, 0, 0, 10));
      place_joints(0, 0, 0, 0);
      send_tick(make_tick(ModeNormal, 0, 0, 0, 0, 100));
   endtask

   task automatic test_truncation();
      send_tick(make_tick(ModeNormal, -1999, 1999, -999, 999, 1));
      send_tick(make_tick(ModeNormal, -1000, 1001, -1001, 1000, 999));
      send_tick(make_tick(ModeNormal, SpdTop, -SpdTop - 1, SpdTop, -SpdTop - 1, 0));
   endtask

   task automatic test_parallel_limits();
      place_joints(0, -5000, 80000, 0);
      send_tick(make_tick(ModeNormal, 0, 0, 1000, 0, 10));
      send_tick(make_tick(ModeNormal, 0, 500, 500, 0, 10));
      send_tick(make_tick(ModeNormal, 0, 1000, 0, 0, 10));
      place_joints(0, 80000, -5000, 0);
      send_tick(make_tick(ModeNormal, 0, 0, -1000, 0, 10));
      send_tick(make_tick(ModeNormal, 0, -1000, 0, 0, 10));
      place_joints(0, 0, 0, 0);
   endtask

   task automatic test_limit_registers();
      limit_set_type s;
      s = pick_limits(LIM_DEFAULT);
      s[REG_AXIS1_NEG] = LimW'(LimFloor);
      s[REG_AXIS1_POS] = LimW'(LimCeil);
      s[REG_AXIS2_NEG] = LimW'(-LimSpan);
      s[REG_AXIS2_POS] = LimW'(LimSpan);
      // axis 3 limits swapped, axis 4 limits equal
      s[REG_AXIS3_NEG] = LimW'(5000);
      s[REG_AXIS3_POS] = LimW'(-5000);
      s[REG_AXIS4_NEG] = '0;
      s[REG_AXIS4_POS] = '0;
      program_limits(s);
      place_joints(0, 0, 0, 0);
      send_tick(make_tick(ModeNormal, 0, 0, 100, 0, 10));
      send_tick(make_tick(ModeNormal, 0, 0, 0, 700, 10));
      send_tick(make_tick(ModeNormal, 0, 0, 0, 700, 10));
      send_tick(make_tick(ModeNormal, 0, 0, -100, -2000, 10));
      send_tick(make_tick(ModeNormal, 0, 0, 0, -2000, 10));
      program_limits(pick_limits(LIM_DEFAULT));
   endtask

   task automatic test_random_motion(input int n_ticks, input lim_style_type style);
      tick_word_type t;
      int            dir [NumAxes];
      int            tgt [NumAxes];
      int            stop_at;
      int            next_pause;
      int            seg_len;
      int            mag;
      int            ms_top;
      int            r;
      int            v;
      int            k;
      logic          far;
      stop_at = ticks_sent + n_ticks;
      program_limits(pick_limits(style));
      next_pause = ticks_sent + int'($urandom_range(80, 160));
      while (ticks_sent < stop_at) begin
         if (ticks_sent >= next_pause) begin
            wait_for_poses();
            if ($urandom_range(1) == 1)
               program_limits(pick_limits(lim_style_type'($urandom_range(3))));
            next_pause = ticks_sent + int'($urandom_range(80, 160));
         end
         far = 1'b0;
         for (k = 0; k < NumAxes; k++)
            if (joint_pos[k] > FarAngle || joint_pos[k] < -FarAngle) far = 1'b1;
         if ((far && $urandom_range(99) < 70) || $urandom_range(99) < 10) begin
            // park near a limit or somewhere inside the range
            for (k = 0; k < NumAxes; k++) begin
               r = $urandom_range(3);
               if (r == 0) tgt[k] = int'(lim_regs[2*k]) + int'($urandom_range(2)) - 1;
               else if (r == 1) tgt[k] = int'(lim_regs[2*k+1]) + int'($urandom_range(2)) - 1;
               else tgt[k] = int'($urandom_range(300000)) - 150000;
            end
            place_joints(tgt[0], tgt[1], tgt[2], tgt[3]);
         end
         for (k = 0; k < NumAxes; k++) dir[k] = int'($urandom_range(2)) - 1;
         case ($urandom_range(2))
            0: mag = 3000;
            1: mag = 60000;
            default: mag = 400000;
         endcase
         case ($urandom_range(2))
            0: ms_top = 20;
            1: ms_top = 100;
            default: ms_top = 400;
         endcase
         seg_len = $urandom_range(5, 40);
         repeat (seg_len) begin
            r = $urandom_range(99);
            if (r < 3) begin
               t.mode = 1'($urandom());
               for (k = 0; k < NumAxes; k++) t.speed[k] = SpdW'($urandom());
               t.ms = MsW'($urandom());
            end else begin
               t.mode = (r < 11) ? ModeHoming : ModeNormal;
               t.ms = ($urandom_range(99) < 5) ? '0 : MsW'($urandom_range(1, ms_top));
               for (k = 0; k < NumAxes; k++) begin
                  v = dir[k] * int'($urandom_range(mag));
                  r = $urandom_range(99);
                  if (r < 12) v = 0;
                  else if (r < 22) v = -v;
                  t.speed[k] = SpdW'(v);
               end
            end
            send_tick(t);
         end
      end
   endtask

   // response side: random stalls and the pose checks
   initial begin
      pose_word_type got;
      pose_word_type want;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) begin
            got.angle[0] = rsp_if.angle1;
            got.angle[1] = rsp_if.angle2;
            got.angle[2] = rsp_if.angle3;
            got.angle[3] = rsp_if.angle4;
            got.alarms = rsp_if.alarm_bits;
            got.blocked = rsp_if.motion_blocked;
            got.vel_clear = rsp_if.single_velocity_clear;
            if (expected_poses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MaxShown)
                  $display("pose word with no tick pending at %0t", $realtime);
            end else begin
               want = expected_poses.pop_front();
               poses_checked++;
               if (want.blocked) blocked_seen++;
               if (want.vel_clear) alarm_seen++;
               if (got.angle !== want.angle || got.alarms !== want.alarms ||
                   got.blocked !== want.blocked || got.vel_clear !== want.vel_clear) begin
                  mismatch_count++;
                  if (mismatch_count <= MaxShown) begin
                     $display("pose %0d wrong at %0t", poses_checked, $realtime);
                     $display("  want angles %0d %0d %0d %0d alarms %h blocked %b clear %b",
                              $signed(want.angle[0]), $signed(want.angle[1]),
                              $signed(want.angle[2]), $signed(want.angle[3]),
                              want.alarms, want.blocked, want.vel_clear);
                     $display("  got  angles %0d %0d %0d %0d alarms %h blocked %b clear %b",
                              $signed(got.angle[0]), $signed(got.angle[1]),
                              $signed(got.angle[2]), $signed(got.angle[3]),
                              got.alarms, got.blocked, got.vel_clear);
                  end
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
   end

   initial begin
      int i;
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.mode <= ModeNormal;
      req_if.axis1_speed <= '0;
      req_if.axis2_speed <= '0;
      req_if.axis3_speed <= '0;
      req_if.axis4_speed <= '0;
      req_if.elapsed_ms <= '0;
      csr_if.valid <= 1'b0;
      csr_if.addr <= '0;
      csr_if.wdata <= '0;
      for (i = 0; i < NumLimits; i++) lim_regs[i] = LimReset[i];
      for (i = 0; i < NumAxes; i++) joint_pos[i] = '0;
      alarm_hold = '0;
      src_idle_pct = 8;
      snk_idle_pct = 48;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_overflow_and_homing();
      test_truncation();
      test_parallel_limits();
      test_limit_registers();

      test_random_motion(470, LIM_DEFAULT);
      wait_for_poses();
      src_idle_pct = 48;
      snk_idle_pct = 8;
      test_random_motion(460, LIM_ORDERED);
      wait_for_poses();
      src_idle_pct = 0;
      snk_idle_pct = 0;
      test_random_motion(460, LIM_EXTREME);
      wait_for_poses();

      $display("%0d ticks (%0d homing), %0d poses checked, %0d blocked, %0d with alarms",
               ticks_sent, homing_sent, poses_checked, blocked_seen, alarm_seen);
      $display("%0d limit settings programmed", limit_sets);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/jsli_pkg.sv
rtl/jsli_if.sv
rtl/jsli_delta.sv
rtl/joint_soft_limit_integrator_core.sv
dv/joint_soft_limit_integrator_core_test.sv
